// ===== hdl/pnse_pkg.sv =====
// ---------------------------------------------------------------------------
// pnse_pkg
// Shared types and constants of the petri net step engine: widths, register
// indexes, sequencer states and the control bundle from sequencer to datapath.
// ---------------------------------------------------------------------------
`default_nettype none

package pnse_pkg;

  // default net size
  localparam int PLACES_DEF = 8;
  localparam int TRANS_DEF  = 8;

  // fixed field widths
  localparam int COUNT_W     = 8;
  localparam int MASK_W      = 8;
  localparam int MAT_W       = 64;
  localparam int TCOUNT_W    = 4;
  localparam int IDX_W       = 3;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 80;
  localparam int CFG_IDX_W   = 2;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 8'hFF;
  localparam logic [TCOUNT_W-1:0] TCOUNT_RST = 4'd8;

  // item kinds
  localparam logic KIND_EVAL   = 1'b0;
  localparam logic KIND_RELOAD = 1'b1;

  typedef logic [COUNT_W-1:0] count_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PRE_MATRIX      = 2'd0,
    REG_POST_MATRIX     = 2'd1,
    REG_INITIAL_MARKING = 2'd2,
    REG_TRANSITION_CNT  = 2'd3
  } cfg_reg_t;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_WRITE
  } state_t;

  // sequencer to datapath controls
  typedef struct packed {
    logic             start;
    logic             reload;
    logic             step;
    logic [IDX_W-1:0] t_idx;
    logic             publish;
  } ctrl_t;

endpackage

`default_nettype wire

// ===== hdl/pnse_fire_unit.sv =====
// ---------------------------------------------------------------------------
// pnse_fire_unit
// Shared transition evaluator: checks enabling of one transition against the
// working marking and computes the marking update of its firing.
// ---------------------------------------------------------------------------
`default_nettype none

module pnse_fire_unit #(
  parameter int PLACES = pnse_pkg::PLACES_DEF
) (
  input  wire logic                              cond_bit,
  input  wire logic [pnse_pkg::MASK_W-1:0]       pre_row,
  input  wire logic [pnse_pkg::MASK_W-1:0]       post_row,
  input  wire pnse_pkg::count_t [PLACES-1:0]     work,
  input  wire pnse_pkg::count_t [PLACES-1:0]     counts,
  output logic                                   fire,
  output pnse_pkg::count_t [PLACES-1:0]          work_next,
  output pnse_pkg::count_t [PLACES-1:0]          counts_next,
  output logic                                   sat
);

  logic                           enabled;
  pnse_pkg::count_t [PLACES-1:0]  dec;

  // enabling: every input place holds a token in the working marking
  always_comb begin
    enabled = cond_bit;
    for (int p = 0; p < PLACES; p++) begin
      if (pre_row[p] && (work[p] == '0)) begin
        enabled = 1'b0;
      end
    end
  end

  assign fire = enabled;

  // consume from input places, then produce into output places with clamp
  always_comb begin
    sat = 1'b0;
    for (int p = 0; p < PLACES; p++) begin
      dec[p]         = counts[p];
      work_next[p]   = work[p];
      counts_next[p] = counts[p];
      if (enabled) begin
        if (pre_row[p] && (counts[p] != '0)) begin
          dec[p] = counts[p] - pnse_pkg::COUNT_W'(1);
        end
        if (pre_row[p] && (work[p] != '0)) begin
          work_next[p] = work[p] - pnse_pkg::COUNT_W'(1);
        end
        counts_next[p] = dec[p];
        if (post_row[p]) begin
          if (dec[p] == pnse_pkg::COUNT_MAX) begin
            sat = 1'b1;
          end else begin
            counts_next[p] = dec[p] + pnse_pkg::COUNT_W'(1);
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/pnse_seq.sv =====
// ---------------------------------------------------------------------------
// pnse_seq
// Step sequencer: takes one item, walks the transitions one per cycle through
// the shared fire unit, then hands the result to the output register.
// ---------------------------------------------------------------------------
`default_nettype none

module pnse_seq #(
  parameter int TRANSITIONS = pnse_pkg::TRANS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_tvalid,
  input  wire logic                          kind,
  input  wire logic [pnse_pkg::TCOUNT_W-1:0] transition_count,
  input  wire logic                          out_free,
  output logic                               s_tready,
  output pnse_pkg::ctrl_t                    ctrl
);

  localparam int TW = $clog2(TRANSITIONS + 1);

  pnse_pkg::state_t state, state_next;
  logic [TW-1:0]    cnt, cnt_next;
  logic [TW-1:0]    nt;
  logic [TW-1:0]    nt_in;
  logic             accept;
  logic             last;

  // clamp the transition count to the built size
  assign nt_in = (transition_count > pnse_pkg::TCOUNT_W'(TRANSITIONS)) ?
                 TW'(TRANSITIONS) : TW'(transition_count);

  assign accept = (state == pnse_pkg::ST_IDLE) && s_tvalid;
  assign last   = ((cnt + TW'(1)) == nt);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      pnse_pkg::ST_IDLE: begin
        if (s_tvalid) begin
          if ((kind == pnse_pkg::KIND_RELOAD) || (nt_in == '0)) begin
            state_next = pnse_pkg::ST_WRITE;
          end else begin
            state_next = pnse_pkg::ST_RUN;
          end
        end
      end
      pnse_pkg::ST_RUN: begin
        if (last) begin
          state_next = pnse_pkg::ST_WRITE;
        end
      end
      pnse_pkg::ST_WRITE: begin
        if (out_free) begin
          state_next = pnse_pkg::ST_IDLE;
        end
      end
      default: state_next = pnse_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    s_tready     = 1'b0;
    ctrl.start   = 1'b0;
    ctrl.reload  = kind;
    ctrl.step    = 1'b0;
    ctrl.t_idx   = pnse_pkg::IDX_W'(cnt);
    ctrl.publish = 1'b0;
    cnt_next     = cnt;
    case (state)
      pnse_pkg::ST_IDLE: begin
        s_tready   = 1'b1;
        ctrl.start = s_tvalid;
        cnt_next   = '0;
      end
      pnse_pkg::ST_RUN: begin
        ctrl.step = 1'b1;
        cnt_next  = cnt + TW'(1);
      end
      pnse_pkg::ST_WRITE: begin
        ctrl.publish = out_free;
      end
      default: begin
        cnt_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pnse_pkg::ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  // transition count latched per item
  always_ff @(posedge clk) begin
    if (accept) begin
      nt <= nt_in;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/petri_net_step_engine_core.sv =====
// ---------------------------------------------------------------------------
// petri_net_step_engine_core
// One step of a Petri net with unit arc weights: transitions are visited in
// index order through one shared fire unit; the result carries the fired
// mask, the new marking and a saturation flag. A reload item restores the
// initial marking.
// ---------------------------------------------------------------------------
//
//  channel   dir  handshake                  contents
//  s_*       in   s_tvalid / s_tready        tdata: condition_mask; tuser: kind
//  m_*       out  m_tvalid / m_tready        tdata: fired_mask, marking, saturated
//  cfg_*     in   cfg_we                     cfg_index selects register, cfg_data
//
//  sequence: an evaluate item steps through ST_RUN for nt transitions, then ST_WRITE,
//    nt = min(transition_count, TRANSITIONS); the fire unit handles one transition per
//    cycle. A reload item goes straight to ST_WRITE; a new item is taken only in ST_IDLE.
//  reset: rst is synchronous; it clears the marking, the sequencer and the
//    output valid, and sets the configuration to its reset values.
//  stalls: a held result stalls the sequencer only at its write step; the
//    next item is accepted while an earlier result waits in the output
//    register.
// ---------------------------------------------------------------------------
`default_nettype none

module petri_net_step_engine_core #(
  parameter int PLACES      = pnse_pkg::PLACES_DEF,
  parameter int TRANSITIONS = pnse_pkg::TRANS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // input item
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  input  wire logic [pnse_pkg::IN_TDATA_W-1:0]  s_tdata,  // [7:0] condition_mask
  input  wire logic                             s_tuser,  // [0] kind
  // result item
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  // [7:0] fired_mask, [71:8] marking_out, [72] count_saturated, [79:73] zero
  output logic [pnse_pkg::OUT_TDATA_W-1:0]      m_tdata,
  // configuration
  input  wire logic                             cfg_we,
  input  wire logic [pnse_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [pnse_pkg::MAT_W-1:0]       cfg_data
);

  // configuration registers
  logic [pnse_pkg::MAT_W-1:0]    pre_matrix;
  logic [pnse_pkg::MAT_W-1:0]    post_matrix;
  logic [pnse_pkg::MAT_W-1:0]    initial_marking;
  logic [pnse_pkg::TCOUNT_W-1:0] transition_count;

  // marking and per-step state
  pnse_pkg::count_t [PLACES-1:0] counts;
  pnse_pkg::count_t [PLACES-1:0] work;
  logic [pnse_pkg::MASK_W-1:0]   cond;
  logic [pnse_pkg::MASK_W-1:0]   fired;
  logic [pnse_pkg::MASK_W-1:0]   fired_next;
  logic                          sat;

  // fire unit interface
  logic [pnse_pkg::MASK_W-1:0]   pre_row;
  logic [pnse_pkg::MASK_W-1:0]   post_row;
  logic                          fire;
  logic                          unit_sat;
  pnse_pkg::count_t [PLACES-1:0] work_upd;
  pnse_pkg::count_t [PLACES-1:0] counts_upd;

  pnse_pkg::ctrl_t               ctrl;
  logic                          out_free;
  logic [pnse_pkg::MAT_W-1:0]    marking_out;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      pre_matrix       <= '0;
      post_matrix      <= '0;
      initial_marking  <= '0;
      transition_count <= pnse_pkg::TCOUNT_RST;
    end else if (cfg_we) begin
      case (pnse_pkg::cfg_reg_t'(cfg_index))
        pnse_pkg::REG_PRE_MATRIX:      pre_matrix      <= cfg_data;
        pnse_pkg::REG_POST_MATRIX:     post_matrix     <= cfg_data;
        pnse_pkg::REG_INITIAL_MARKING: initial_marking <= cfg_data;
        pnse_pkg::REG_TRANSITION_CNT:  transition_count <= cfg_data[pnse_pkg::TCOUNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign out_free = !m_tvalid || m_tready;

  pnse_seq #(
    .TRANSITIONS (TRANSITIONS)
  ) u_seq (
    .clk              (clk),
    .rst              (rst),
    .s_tvalid         (s_tvalid),
    .kind             (s_tuser),
    .transition_count (transition_count),
    .out_free         (out_free),
    .s_tready         (s_tready),
    .ctrl             (ctrl)
  );

  // rows of the current transition
  assign pre_row  = pre_matrix[pnse_pkg::MASK_W*ctrl.t_idx +: pnse_pkg::MASK_W];
  assign post_row = post_matrix[pnse_pkg::MASK_W*ctrl.t_idx +: pnse_pkg::MASK_W];

  pnse_fire_unit #(
    .PLACES (PLACES)
  ) u_fire (
    .cond_bit    (cond[ctrl.t_idx]),
    .pre_row     (pre_row),
    .post_row    (post_row),
    .work        (work),
    .counts      (counts),
    .fire        (fire),
    .work_next   (work_upd),
    .counts_next (counts_upd),
    .sat         (unit_sat)
  );

  always_comb begin
    fired_next = fired;
    fired_next[ctrl.t_idx] = fired[ctrl.t_idx] | fire;
  end

  // marking: reload loads it, each step applies the fire unit update
  always_ff @(posedge clk) begin
    if (rst) begin
      counts <= '0;
    end else if (ctrl.start && (ctrl.reload == pnse_pkg::KIND_RELOAD)) begin
      for (int p = 0; p < PLACES; p++) begin
        counts[p] <= initial_marking[pnse_pkg::COUNT_W*p +: pnse_pkg::COUNT_W];
      end
    end else if (ctrl.step) begin
      counts <= counts_upd;
    end
  end

  // working marking, condition bits, fired mask, saturation flag
  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      work  <= counts;
      cond  <= s_tdata[pnse_pkg::MASK_W-1:0];
      fired <= '0;
      sat   <= 1'b0;
    end else if (ctrl.step) begin
      work  <= work_upd;
      fired <= fired_next;
      sat   <= sat | unit_sat;
    end
  end

  // pack the marking, unused places read as zero
  always_comb begin
    marking_out = '0;
    for (int p = 0; p < PLACES; p++) begin
      marking_out[pnse_pkg::COUNT_W*p +: pnse_pkg::COUNT_W] = counts[p];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else begin
      m_tvalid <= ctrl.publish || (m_tvalid && !m_tready);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.publish) begin
      m_tdata <= {7'b0, sat, marking_out, fired};
    end
  end

  // busy right after an accepted item
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("block ready in the cycle after accepting an item");

  // only transitions in use are visited
  a_step_in_range: assert property (@(posedge clk) disable iff (rst)
    ctrl.step |-> (pnse_pkg::TCOUNT_W'(ctrl.t_idx) < transition_count))
    else $error("step visits a transition beyond the transition count");

  // no fired bit at or above the transition count
  a_fired_in_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((m_tdata[pnse_pkg::MASK_W-1:0] >> transition_count) == '0))
    else $error("fired mask holds a bit of an unused transition");

endmodule

`default_nettype wire

// ===== bench/tb_petri_net_step_engine_core.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_petri_net_step_engine_core
// Self-checking bench for the net step engine: a scoreboard plays each
// accepted item on its own copy of the marking and net registers and checks
// every result item field by field; directed nets first, then random nets.
// ---------------------------------------------------------------------------

module tb_petri_net_step_engine_core;

  localparam int CLK_HALF   = 6;
  localparam int CYCLE_CAP  = 300000;
  localparam int NET_PHASES = 20;
  localparam int PHASE_LEN  = 85;
  localparam int HOLD_AT    = 400;
  localparam int HOLD_LEN   = 100;
  localparam int SETTLE     = 12;

  // expected fields of one result item
  typedef struct {
    logic [pnse_pkg::MASK_W-1:0] fired;
    logic [pnse_pkg::MAT_W-1:0]  marking;
    logic                        saturated;
  } step_result_t;

  // reference net: marking, net registers and the queue of expected steps
  class step_checker;
    logic [pnse_pkg::MAT_W-1:0]    pre_rows;
    logic [pnse_pkg::MAT_W-1:0]    post_rows;
    logic [pnse_pkg::MAT_W-1:0]    load_marking;
    logic [pnse_pkg::TCOUNT_W-1:0] tcount;
    pnse_pkg::count_t              tokens [8];
    step_result_t                  expected_steps [$];
    int                            errors;

    function new();
      pre_rows     = '0;
      post_rows    = '0;
      load_marking = '0;
      tcount       = pnse_pkg::TCOUNT_RST;
      foreach (tokens[p]) tokens[p] = '0;
      errors       = 0;
    endfunction

    function void set_reg(pnse_pkg::cfg_reg_t idx, logic [pnse_pkg::MAT_W-1:0] val);
      case (idx)
        pnse_pkg::REG_PRE_MATRIX:      pre_rows     = val;
        pnse_pkg::REG_POST_MATRIX:     post_rows    = val;
        pnse_pkg::REG_INITIAL_MARKING: load_marking = val;
        pnse_pkg::REG_TRANSITION_CNT:  tcount       = val[pnse_pkg::TCOUNT_W-1:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_steps.size();
    endfunction

    // play one net step (or a reload) on the marking
    function void note_item(logic kind, logic [pnse_pkg::MASK_W-1:0] cond);
      step_result_t                r;
      pnse_pkg::count_t            work [8];
      logic [pnse_pkg::MASK_W-1:0] pre_row, post_row;
      int                          nt;
      bit                          enabled;
      r.fired     = '0;
      r.saturated = 1'b0;
      if (kind == pnse_pkg::KIND_RELOAD) begin
        for (int p = 0; p < 8; p++) tokens[p] = load_marking[8*p +: 8];
      end else begin
        nt = (tcount > 8) ? 8 : tcount;
        foreach (work[p]) work[p] = tokens[p];
        for (int t = 0; t < nt; t++) begin
          pre_row  = pre_rows[8*t +: 8];
          post_row = post_rows[8*t +: 8];
          enabled  = cond[t];
          for (int p = 0; p < 8; p++)
            if (pre_row[p] && work[p] == 0) enabled = 0;
          if (enabled) begin
            r.fired[t] = 1'b1;
            // consume from both markings, produce into the new one only
            for (int p = 0; p < 8; p++) begin
              if (pre_row[p]) begin
                if (tokens[p] != 0) tokens[p] = tokens[p] - pnse_pkg::count_t'(1);
                if (work[p] != 0) work[p] = work[p] - pnse_pkg::count_t'(1);
              end
            end
            for (int p = 0; p < 8; p++) begin
              if (post_row[p]) begin
                if (tokens[p] == pnse_pkg::COUNT_MAX) r.saturated = 1'b1;
                else tokens[p] = tokens[p] + pnse_pkg::count_t'(1);
              end
            end
          end
        end
      end
      for (int p = 0; p < 8; p++) r.marking[8*p +: 8] = tokens[p];
      expected_steps.push_back(r);
    endfunction

    function void flag(string what, logic [pnse_pkg::MAT_W-1:0] exp_val,
                       logic [pnse_pkg::MAT_W-1:0] got);
      errors++;
      if (errors <= 10)
        $display("mismatch %s: expected %h, got %h (at %0t)", what, exp_val, got, $realtime);
    endfunction

    function void check_result(logic [pnse_pkg::OUT_TDATA_W-1:0] d);
      step_result_t e;
      if (expected_steps.size() == 0) begin
        flag("unexpected result item", '0, d[71:8]);
        return;
      end
      e = expected_steps.pop_front();
      if (d[7:0] !== e.fired)
        flag("fired_mask", pnse_pkg::MAT_W'(e.fired), pnse_pkg::MAT_W'(d[7:0]));
      if (d[71:8] !== e.marking) flag("marking_out", e.marking, d[71:8]);
      if (d[72] !== e.saturated)
        flag("count_saturated", pnse_pkg::MAT_W'(e.saturated), pnse_pkg::MAT_W'(d[72]));
      if (d[79:73] !== 7'd0) flag("tdata padding", '0, pnse_pkg::MAT_W'(d[79:73]));
    endfunction
  endclass

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             s_tvalid = 1'b0;
  logic                             s_tready;
  logic [pnse_pkg::IN_TDATA_W-1:0]  s_tdata = '0;   // [7:0] condition_mask
  logic                             s_tuser = 1'b0; // [0] kind
  logic                             m_tvalid;
  logic                             m_tready = 1'b0;
  // [7:0] fired_mask, [71:8] marking_out, [72] count_saturated
  logic [pnse_pkg::OUT_TDATA_W-1:0] m_tdata;
  logic                             cfg_we = 1'b0;
  logic [pnse_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
  logic [pnse_pkg::MAT_W-1:0]       cfg_data = '0;

  step_checker net_sb = new();
  int          items_sent = 0;
  bit          quiet = 0;
  int          cycles = 0;

  petri_net_step_engine_core dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #(CLK_HALF) clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_CAP) begin
      $display("simulation failed");
      $finish;
    end
  end

  // handshake monitors
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) net_sb.note_item(s_tuser, s_tdata);
    if (!rst && m_tvalid && m_tready) net_sb.check_result(m_tdata);
  end

  // result side: short random stalls plus one long hold-off
  initial begin
    int  stall_left;
    bit  hold_done;
    stall_left = 0;
    hold_done  = 0;
    forever begin
      @(negedge clk);
      if (!hold_done && items_sent >= HOLD_AT) begin
        hold_done = 1;
        m_tready <= 1'b0;
        repeat (HOLD_LEN - 1) @(negedge clk);
      end else if (stall_left > 0) begin
        m_tready <= 1'b0;
        stall_left--;
      end else if (!quiet && $urandom_range(0, 6) == 0) begin
        m_tready <= 1'b0;
        stall_left = $urandom_range(0, 2);
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // offer one item, with an occasional gap before it
  task automatic send_item(input logic kind, input logic [pnse_pkg::MASK_W-1:0] cond);
    @(negedge clk);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= cond;
    do @(posedge clk); while (!s_tready);
    items_sent++;
  endtask

  task automatic write_reg(input pnse_pkg::cfg_reg_t idx,
                           input logic [pnse_pkg::MAT_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    net_sb.set_reg(idx, val);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic write_net(input logic [pnse_pkg::MAT_W-1:0] pre,
                           input logic [pnse_pkg::MAT_W-1:0] post,
                           input logic [pnse_pkg::MAT_W-1:0] init,
                           input logic [pnse_pkg::TCOUNT_W-1:0] tc);
    write_reg(pnse_pkg::REG_PRE_MATRIX, pre);
    write_reg(pnse_pkg::REG_POST_MATRIX, post);
    write_reg(pnse_pkg::REG_INITIAL_MARKING, init);
    write_reg(pnse_pkg::REG_TRANSITION_CNT, pnse_pkg::MAT_W'(tc));
  endtask

  // stop offering and wait until every expected result is out
  task automatic drain();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (net_sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic logic [pnse_pkg::MASK_W-1:0] rand_row();
    case ($urandom_range(0, 5))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h01 << $urandom_range(0, 7);
      3, 4: return 8'($urandom) & 8'($urandom);
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic pnse_pkg::count_t rand_count();
    case ($urandom_range(0, 4))
      0: return pnse_pkg::count_t'($urandom_range(0, 3));
      1: return pnse_pkg::count_t'($urandom_range(250, 255));
      2: return 8'd1;
      default: return pnse_pkg::count_t'($urandom);
    endcase
  endfunction

  initial begin
    logic [pnse_pkg::MAT_W-1:0]    pre, post, init;
    logic [pnse_pkg::TCOUNT_W-1:0] tc;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // registers at reset values: empty rows, all transitions in use
    send_item(pnse_pkg::KIND_EVAL, 8'hFF);
    send_item(pnse_pkg::KIND_EVAL, 8'h00);
    send_item(pnse_pkg::KIND_RELOAD, 8'h00);
    drain();

    // competing inputs, empty input mask, self loop, saturation, blocked places
    write_net(64'h10FF2002_08000101, 64'h40801001_08040002,
              64'h000005FE_02FF0001, 4'd8);
    send_item(pnse_pkg::KIND_RELOAD, 8'h00);
    send_item(pnse_pkg::KIND_EVAL, 8'hFF);
    send_item(pnse_pkg::KIND_EVAL, 8'hFF);
    send_item(pnse_pkg::KIND_EVAL, 8'h55);
    send_item(pnse_pkg::KIND_EVAL, 8'hAA);
    send_item(pnse_pkg::KIND_RELOAD, 8'hFF);
    send_item(pnse_pkg::KIND_EVAL, 8'hFF);
    drain();

    // zero transitions, oversized count, unused condition bits
    write_reg(pnse_pkg::REG_TRANSITION_CNT, pnse_pkg::MAT_W'(4'd0));
    send_item(pnse_pkg::KIND_EVAL, 8'hFF);
    drain();
    write_reg(pnse_pkg::REG_TRANSITION_CNT, pnse_pkg::MAT_W'(4'd15));
    send_item(pnse_pkg::KIND_RELOAD, 8'h00);
    send_item(pnse_pkg::KIND_EVAL, 8'hFF);
    drain();
    write_reg(pnse_pkg::REG_TRANSITION_CNT, pnse_pkg::MAT_W'(4'd3));
    send_item(pnse_pkg::KIND_EVAL, 8'hF8);
    send_item(pnse_pkg::KIND_EVAL, 8'hFF);
    drain();

    // all-ones net: full places, full rows
    write_net('1, '1, '1, 4'd8);
    send_item(pnse_pkg::KIND_RELOAD, 8'h00);
    send_item(pnse_pkg::KIND_EVAL, 8'hFF);
    send_item(pnse_pkg::KIND_EVAL, 8'h01);
    drain();
    write_reg(pnse_pkg::REG_PRE_MATRIX, '0);
    send_item(pnse_pkg::KIND_EVAL, 8'hFF);
    send_item(pnse_pkg::KIND_RELOAD, 8'h00);
    drain();

    // random nets; the last two run without idling
    for (int ph = 0; ph < NET_PHASES; ph++) begin
      if (ph >= NET_PHASES - 2) quiet = 1;
      for (int t = 0; t < 8; t++) begin
        pre[8*t +: 8]  = rand_row();
        post[8*t +: 8] = rand_row();
        init[8*t +: 8] = rand_count();
      end
      tc = ($urandom_range(0, 9) < 6) ? 4'd8 : pnse_pkg::TCOUNT_W'($urandom_range(0, 15));
      write_net(pre, post, init, tc);
      send_item(pnse_pkg::KIND_RELOAD, 8'($urandom));
      for (int i = 1; i < PHASE_LEN; i++) begin
        if ($urandom_range(0, 7) == 0) send_item(pnse_pkg::KIND_RELOAD, 8'($urandom));
        else if ($urandom_range(0, 5) == 0) send_item(pnse_pkg::KIND_EVAL, 8'hFF);
        else send_item(pnse_pkg::KIND_EVAL, 8'($urandom));
      end
      drain();
    end

    if (net_sb.errors == 0 && net_sb.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
